FILE: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, held off while in reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

FILE: sv/fss_pkg.sv
`default_nettype none
package fss_pkg;

	localparam int CAPACITY   = 1024;
	localparam int NAME_CHARS = 20;
	localparam int FULL_CHARS = 20;
	localparam int NAME_W     = FULL_CHARS * 8;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int COUNT_W    = 11;
	localparam int IN_DATA_W  = NAME_W;
	localparam int OUT_DATA_W = ((NAME_W + COUNT_W + 7) / 8) * 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [NAME_W-1:0] name;
	} cell_ctrl_t;

	// 7-bit chars, zero after the first NUL or past NAME_CHARS
	function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw);
		logic [FULL_CHARS-1:0] stop;
		logic [NAME_W-1:0]     res;
		logic [7:0]            byte_v;
		logic                  dead;
		stop = '0;
		res  = '0;
		for (int i = 0; i < FULL_CHARS; i++) begin
			byte_v  = raw[NAME_W-1-8*i -: 8];
			stop[i] = (byte_v[6:0] == 7'd0) || (i >= NAME_CHARS);
		end
		for (int i = 0; i < FULL_CHARS; i++) begin
			byte_v = raw[NAME_W-1-8*i -: 8];
			dead   = 1'b0;
			for (int j = 0; j <= i; j++) begin
				dead = dead | stop[j];
			end
			res[NAME_W-1-8*i -: 8] = dead ? 8'd0 : {1'b0, byte_v[6:0]};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: sv/fss_cell.sv
`default_nettype none
module fss_cell
	import fss_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic              occupied,
	input  wire logic              prev_gt,
	input  wire logic [NAME_W-1:0] prev_name,
	input  wire logic [NAME_W-1:0] next_name,
	output logic                   gt,
	output logic [NAME_W-1:0]      name
);

	logic [NAME_W-1:0] name_q;

	// empty slots count as greater so the first free one takes the name
	assign gt   = !occupied || (name_q > ctrl.name);
	assign name = name_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_gt) begin
				name_q <= prev_name;
			end else if (gt) begin
				name_q <= ctrl.name;
			end
		end else if (ctrl.pop) begin
			name_q <= next_name;
		end
	end

endmodule
`default_nettype wire

FILE: sv/fixed_width_string_sorter_unit.sv
`default_nettype none
// A result word appears on m_tvalid the cycle after its input word is accepted.
// One insert or pop per cycle while the output is not stalled; every cell compares
// against the broadcast name and shifts to its neighbor in that same cycle, so nothing iterates.
// Reset: clears the name count and the output valid; cell contents are left as is,
// with no clearing pass, since only cells below the count are ever read.
module fixed_width_string_sorter_unit
	import fss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // chars_0_to_7, chars_8_to_15, chars_16_to_19
	input  wire logic                  s_tuser,  // command
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // out_chars_0_to_7, out_chars_8_to_15,
	                                             // out_chars_16_to_19, stored_count, zero pad
	output logic [1:0]                 m_tuser   // status
);

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	status_t               out_status_q;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	cell_ctrl_t        ctrl;
	logic [NAME_W-1:0] raw_name;
	logic [NAME_W-1:0] names [CAPACITY];
	logic              gts   [CAPACITY];

	logic [CNT_W-1:0]  count_d;
	logic [NAME_W-1:0] res_name;
	status_t           res_status;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_full  = (count_q >= CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// first char sits in the top byte
	assign raw_name  = {s_tdata[63:0], s_tdata[127:64], s_tdata[159:128]};
	assign ctrl.name = normalize_name(raw_name);
	assign ctrl.ins  = accept && (s_tuser == CMD_INSERT) && !is_full;
	assign ctrl.pop  = accept && (s_tuser == CMD_POP) && !is_empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		fss_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (CNT_W'(i) < count_q),
			.prev_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
			.prev_name (names[(i == 0) ? 0 : i - 1]),
			.next_name (names[(i == CAPACITY - 1) ? i : i + 1]),
			.gt        (gts[i]),
			.name      (names[i])
		);
	end

	always_comb begin
		count_d    = count_q;
		res_name   = '0;
		res_status = ST_OK;
		if (s_tuser == CMD_INSERT) begin
			if (is_full) begin
				res_status = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				res_status = ST_EMPTY;
			end else begin
				res_name = names[0];
				count_d  = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q   <= OUT_DATA_W'({COUNT_W'(count_d), res_name[31:0],
				res_name[95:32], res_name[159:96]});
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

FILE: sv/fss_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fss_checker
	import fss_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [1:0]            m_tuser
);

	logic [COUNT_W-1:0] cnt;
	assign cnt = m_tdata[NAME_W +: COUNT_W];

	`ASSERT_IMPLIES(a_count_range, clk, arst_n, m_tvalid, cnt <= COUNT_W'(CAPACITY), "count beyond capacity")
	`ASSERT_IMPLIES(a_full_count, clk, arst_n, m_tvalid && m_tuser == ST_FULL, cnt == COUNT_W'(CAPACITY), "full flag with room left")
	`ASSERT_IMPLIES(a_empty_zero, clk, arst_n, m_tvalid && m_tuser == ST_EMPTY, m_tdata == '0, "empty pop with data")
	`ASSERT_IMPLIES(a_ready_free, clk, arst_n, !m_tvalid, s_tready, "input stalled with output slot free")
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind fixed_width_string_sorter_unit fss_checker u_fss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
